@@ src/mpl_pkg.sv @@
// mpl_pkg: shared constants, widths and codes for the moving-average PID leveler
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package mpl_pkg;

   // filter and sample sizing
   localparam int FILTER_DEPTH = 7;
   localparam int DIST_W       = 16;
   localparam int SUM_W        = DIST_W + $clog2(FILTER_DEPTH);
   localparam int IDX_W        = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

   // divide by FILTER_DEPTH as multiply by rounded-up reciprocal, exact for SUM_W bits
   localparam int     RECIP_SHIFT = SUM_W + $clog2(FILTER_DEPTH);
   localparam longint RECIP_MULT  =
      ((longint'(1) << RECIP_SHIFT) + FILTER_DEPTH - 1) / FILTER_DEPTH;
   localparam int     RECIP_W     = RECIP_SHIFT + 1;
   localparam int     RPROD_W     = SUM_W + RECIP_W;

   // controller datapath widths
   localparam int GAIN_W  = 32;
   localparam int ERR_W   = DIST_W + 1;
   localparam int DERIV_W = ERR_W + 1;
   localparam int INTEG_W = 32;
   localparam int PP_W    = GAIN_W + ERR_W;
   localparam int PI_W    = GAIN_W + INTEG_W;
   localparam int PD_W    = GAIN_W + DERIV_W;
   localparam int ACC_W   = PI_W + 1;
   localparam int Q_FRAC  = 16;
   localparam int QUOT_W  = ACC_W - Q_FRAC;

   // result sizing
   localparam int DRIVE_W     = 9;
   localparam int SPEED_W     = 15;
   localparam int DRIVE_LIMIT = 200;
   localparam int BASE_SPEED  = 30000;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(66);
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = '0;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P = 2'd0,
      CSR_GAIN_I = 2'd1,
      CSR_GAIN_D = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_PRIME = 1'b0,
      OP_LEVEL = 1'b1
   } opcode_type;

   typedef enum logic {
      SIDE_LEFT  = 1'b0,
      SIDE_RIGHT = 1'b1
   } side_type;

endpackage

`default_nettype wire

@@ src/mpl_if.sv @@
// mpl_if: valid/ready channel interfaces for leveler request and response beats
// depends on mpl_pkg for field widths
`default_nettype none

interface mpl_req_if;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [mpl_pkg::DIST_W-1:0] distance;
   logic                      side;

   modport source (output valid, opcode, distance, side, input ready);
   modport sink   (input valid, opcode, distance, side, output ready);
endinterface

interface mpl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mpl_pkg::DRIVE_W-1:0] drive_value;
   logic        [mpl_pkg::SPEED_W-1:0] wheel_speed;

   modport source (output valid, drive_value, wheel_speed, input ready);
   modport sink   (input valid, drive_value, wheel_speed, output ready);
endinterface

`default_nettype wire

@@ src/moving_average_pid_leveler_top.sv @@
// moving_average_pid_leveler_top: moving-average filter feeding a Q16.16 PID step
// depends on mpl_pkg and the channel interfaces in mpl_if.sv

// Each request beat pushes one distance sample into a 7-deep ring with a running
// sum; the filtered distance is that sum divided by 7. A prime beat clears the
// integral, records the filtered distance and gives no response. A level beat
// runs one PID step on the drop of the filtered distance and gives one response
// beat with the drive value, clamped to +/-200 and negated for the right side,
// and the wheel speed 30000 plus drive. The block takes one beat per cycle
// while not stalled; a level beat's response passes through the pipeline:
// ring and sum update, reciprocal divide, error and integral update, gain
// multiplies, accumulate, round and clamp, output register. Each stage holds
// only while the stage after it is full and stalled. The user must write gains
// through the csr port only while no beat is in flight; the block does not enforce it.
`default_nettype none

module moving_average_pid_leveler_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   mpl_req_if.sink                             req_bus,
   mpl_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [mpl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mpl_pkg::GAIN_W-1:0]     csr_wdata
);

   localparam logic [mpl_pkg::IDX_W-1:0] IDX_LAST = mpl_pkg::IDX_W'(mpl_pkg::FILTER_DEPTH - 1);
   localparam logic [mpl_pkg::RECIP_W-1:0] RECIP_K = mpl_pkg::RECIP_W'(mpl_pkg::RECIP_MULT);
   localparam logic signed [mpl_pkg::ACC_W-1:0] ROUND_BIAS =
      mpl_pkg::ACC_W'((longint'(1) << mpl_pkg::Q_FRAC) - 1);

   // gain registers
   logic signed [mpl_pkg::GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;

   // filter state
   logic [mpl_pkg::DIST_W-1:0] ring_ff [mpl_pkg::FILTER_DEPTH];
   logic [mpl_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [mpl_pkg::SUM_W-1:0]  sum_ff, sum_in;

   // controller state
   logic [mpl_pkg::DIST_W-1:0]         prev_ff;
   logic signed [mpl_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic signed [mpl_pkg::ERR_W-1:0]   last_err_ff, last_err_in;

   // stage valids and handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, vo_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;
   logic accept;

   // stage payloads
   logic op1_ff, side1_ff;
   logic op2_ff, side2_ff;
   logic [mpl_pkg::DIST_W-1:0] filt2_ff, filt2_in;
   logic [mpl_pkg::RPROD_W-1:0] rprod;
   logic op3_ff, side3_ff;
   logic signed [mpl_pkg::ERR_W-1:0]   err3_ff, err_in;
   logic signed [mpl_pkg::DERIV_W-1:0] deriv3_ff, deriv_in;
   logic signed [mpl_pkg::INTEG_W:0]   integ_sum;
   logic side4_ff;
   logic signed [mpl_pkg::PP_W-1:0] pp4_ff, pp_in;
   logic signed [mpl_pkg::PI_W-1:0] pi4_ff, pi_in;
   logic signed [mpl_pkg::PD_W-1:0] pd4_ff, pd_in;
   logic side5_ff;
   logic signed [mpl_pkg::ACC_W-1:0] acc5_ff, acc_in;
   logic side6_ff;
   logic signed [mpl_pkg::ACC_W-1:0]   round_sum;
   logic signed [mpl_pkg::QUOT_W-1:0]  quot;
   logic signed [mpl_pkg::DRIVE_W-1:0] clamp6_ff, clamp_in;
   logic signed [mpl_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic [mpl_pkg::SPEED_W-1:0]        speed_ff, speed_in;

   // stage ready chain
   assign rdy_o = !vo_ff || rsp_bus.ready;
   assign rdy6  = !v6_ff || rdy_o;
   assign rdy5  = !v5_ff || rdy6;
   assign rdy4  = !v4_ff || rdy5;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign accept = req_bus.valid && rdy1;

   assign req_bus.ready       = rdy1;
   assign rsp_bus.valid       = vo_ff;
   assign rsp_bus.drive_value = drive_ff;
   assign rsp_bus.wheel_speed = speed_ff;

   // gain register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= mpl_pkg::GAIN_P_RESET;
         gain_i_ff <= mpl_pkg::GAIN_I_RESET;
         gain_d_ff <= mpl_pkg::GAIN_D_RESET;
      end else if (csr_wr_en) begin
         unique case (mpl_pkg::csr_index_type'(csr_index))
            mpl_pkg::CSR_GAIN_P: gain_p_ff <= csr_wdata;
            mpl_pkg::CSR_GAIN_I: gain_i_ff <= csr_wdata;
            mpl_pkg::CSR_GAIN_D: gain_d_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ring push and running sum
   always_comb begin
      sum_in = sum_ff - ring_ff[idx_ff] + mpl_pkg::SUM_W'(req_bus.distance);
      idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mpl_pkg::FILTER_DEPTH; k++) begin
            ring_ff[k] <= '0;
         end
         idx_ff <= '0;
         sum_ff <= '0;
      end else if (accept) begin
         ring_ff[idx_ff] <= req_bus.distance;
         idx_ff          <= idx_in;
         sum_ff          <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         op1_ff   <= req_bus.opcode;
         side1_ff <= req_bus.side;
      end
   end

   // filtered distance by reciprocal multiply
   always_comb begin
      rprod    = mpl_pkg::RPROD_W'(sum_ff) * mpl_pkg::RPROD_W'(RECIP_K);
      filt2_in = rprod[mpl_pkg::RECIP_SHIFT +: mpl_pkg::DIST_W];
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         filt2_ff <= filt2_in;
         op2_ff   <= op1_ff;
         side2_ff <= side1_ff;
      end
   end

   // error, saturating integral and derivative
   always_comb begin
      err_in    = $signed({1'b0, prev_ff}) - $signed({1'b0, filt2_ff});
      deriv_in  = mpl_pkg::DERIV_W'(err_in) - mpl_pkg::DERIV_W'(last_err_ff);
      integ_sum = (mpl_pkg::INTEG_W + 1)'(integ_ff) + (mpl_pkg::INTEG_W + 1)'(err_in);
      if (op2_ff == mpl_pkg::OP_PRIME) begin
         integ_in    = '0;
         last_err_in = last_err_ff;
      end else begin
         last_err_in = err_in;
         if (integ_sum[mpl_pkg::INTEG_W] != integ_sum[mpl_pkg::INTEG_W-1]) begin
            integ_in = integ_sum[mpl_pkg::INTEG_W]
                     ? {1'b1, {(mpl_pkg::INTEG_W-1){1'b0}}}
                     : {1'b0, {(mpl_pkg::INTEG_W-1){1'b1}}};
         end else begin
            integ_in = integ_sum[mpl_pkg::INTEG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else if (v2_ff && rdy3) begin
         prev_ff     <= filt2_ff;
         integ_ff    <= integ_in;
         last_err_ff <= last_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         err3_ff   <= err_in;
         deriv3_ff <= deriv_in;
         op3_ff    <= op2_ff;
         side3_ff  <= side2_ff;
      end
   end

   // gain products
   always_comb begin
      pp_in = mpl_pkg::PP_W'(gain_p_ff) * mpl_pkg::PP_W'(err3_ff);
      pi_in = mpl_pkg::PI_W'(gain_i_ff) * mpl_pkg::PI_W'(integ_ff);
      pd_in = mpl_pkg::PD_W'(gain_d_ff) * mpl_pkg::PD_W'(deriv3_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         pp4_ff   <= pp_in;
         pi4_ff   <= pi_in;
         pd4_ff   <= pd_in;
         side4_ff <= side3_ff;
      end
   end

   // accumulate
   assign acc_in = mpl_pkg::ACC_W'(pp4_ff) + mpl_pkg::ACC_W'(pi4_ff) + mpl_pkg::ACC_W'(pd4_ff);

   always_ff @(posedge clock) begin
      if (rdy5) begin
         acc5_ff  <= acc_in;
         side5_ff <= side4_ff;
      end
   end

   // drop fraction toward zero and clamp
   always_comb begin
      round_sum = acc5_ff + (acc5_ff[mpl_pkg::ACC_W-1] ? ROUND_BIAS : '0);
      quot      = round_sum[mpl_pkg::ACC_W-1:mpl_pkg::Q_FRAC];
      if (quot > mpl_pkg::QUOT_W'(mpl_pkg::DRIVE_LIMIT)) begin
         clamp_in = mpl_pkg::DRIVE_W'(mpl_pkg::DRIVE_LIMIT);
      end else if (quot < mpl_pkg::QUOT_W'(-mpl_pkg::DRIVE_LIMIT)) begin
         clamp_in = mpl_pkg::DRIVE_W'(-mpl_pkg::DRIVE_LIMIT);
      end else begin
         clamp_in = quot[mpl_pkg::DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         clamp6_ff <= clamp_in;
         side6_ff  <= side5_ff;
      end
   end

   // side negation and wheel speed
   always_comb begin
      drive_in = (side6_ff == mpl_pkg::SIDE_RIGHT) ? -clamp6_ff : clamp6_ff;
      speed_in = mpl_pkg::SPEED_W'(mpl_pkg::BASE_SPEED) + mpl_pkg::SPEED_W'(drive_in);
   end

   always_ff @(posedge clock) begin
      if (rdy_o) begin
         drive_ff <= drive_in;
         speed_ff <= speed_in;
      end
   end

   // stage valids; prime beats leave after the integral stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy1)  v1_ff <= req_bus.valid;
         if (rdy2)  v2_ff <= v1_ff;
         if (rdy3)  v3_ff <= v2_ff;
         if (rdy4)  v4_ff <= v3_ff && (op3_ff == mpl_pkg::OP_LEVEL);
         if (rdy5)  v5_ff <= v4_ff;
         if (rdy6)  v6_ff <= v5_ff;
         if (rdy_o) vo_ff <= v6_ff;
      end
   end

   // checks
   a_drive_in_range: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> (drive_ff <= mpl_pkg::DRIVE_W'(mpl_pkg::DRIVE_LIMIT)) &&
                (drive_ff >= mpl_pkg::DRIVE_W'(-mpl_pkg::DRIVE_LIMIT)))
      else $error("drive value out of clamp range");

   a_speed_tracks_drive: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> speed_ff == mpl_pkg::SPEED_W'(mpl_pkg::BASE_SPEED) + mpl_pkg::SPEED_W'(drive_ff))
      else $error("wheel speed does not match drive value");

   a_prime_clears_integral: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && rdy3 && op2_ff == mpl_pkg::OP_PRIME) |=> integ_ff == '0)
      else $error("integral not cleared by prime beat");

   a_index_in_ring: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_LAST)
      else $error("ring index past filter depth");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for moving_average_pid_leveler_top, predicts each level beat
// depends on mpl_pkg, mpl_if.sv (channel interfaces) and the leveler top level
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_CAP   = 40;
   // index past the last gain register, writes there must be dropped
   localparam logic [mpl_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint INTEG_MAX = 64'sd2147483647;
   localparam longint INTEG_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [mpl_pkg::DRIVE_W-1:0] drive;
      logic        [mpl_pkg::SPEED_W-1:0] speed;
   } drive_result_type;

   logic clock;
   logic reset;
   logic                          csr_wr_en;
   logic [mpl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mpl_pkg::GAIN_W-1:0]    csr_wdata;

   mpl_req_if req_bus ();
   mpl_rsp_if rsp_bus ();

   moving_average_pid_leveler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // leveler state as the bench sees it
   logic [mpl_pkg::DIST_W-1:0] filter_taps [mpl_pkg::FILTER_DEPTH];
   int unsigned       tap_pos;
   int unsigned       tap_sum;
   longint            prev_level;
   longint            integ_acc;
   longint            prev_error;
   longint            kp_q16;
   longint            ki_q16;
   longint            kd_q16;

   drive_result_type pending_drive_q [$];

   int mismatch_count  = 0;
   int beats_sent      = 0;
   int level_beats     = 0;
   int results_checked = 0;
   int gain_settings   = 0;

   // idle shaping on both channels
   bit sender_calm      = 0;
   bit receiver_calm    = 0;
   int send_quiet_left  = 0;
   int rsp_stall_left   = 0;
   int rsp_quiet_left   = 0;
   int rsp_hold_cycles  = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("moving_average_pid_leveler_top: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint want, input longint got);
      begin
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   task automatic clear_leveler_state();
      int k;
      begin
         for (k = 0; k < mpl_pkg::FILTER_DEPTH; k++)
            filter_taps[k] = '0;
         tap_pos    = 0;
         tap_sum    = 0;
         prev_level = 0;
         integ_acc  = 0;
         prev_error = 0;
         kp_q16     = longint'(signed'(mpl_pkg::GAIN_P_RESET));
         ki_q16     = longint'(signed'(mpl_pkg::GAIN_I_RESET));
         kd_q16     = longint'(signed'(mpl_pkg::GAIN_D_RESET));
      end
   endtask

   // one accepted request beat through the filter and the pid step
   task automatic advance_leveler(input mpl_pkg::opcode_type op,
                                  input logic [mpl_pkg::DIST_W-1:0] distance,
                                  input mpl_pkg::side_type sd);
      longint           filtered, err, deriv, acc, drive;
      drive_result_type res;
      begin
         tap_sum = tap_sum - filter_taps[tap_pos] + distance;
         filter_taps[tap_pos] = distance;
         tap_pos = (tap_pos + 1 >= mpl_pkg::FILTER_DEPTH) ? 0 : tap_pos + 1;
         filtered = tap_sum / mpl_pkg::FILTER_DEPTH;

         if (op == mpl_pkg::OP_PRIME) begin
            integ_acc  = 0;
            prev_level = filtered;
            return;
         end

         err = prev_level - filtered;
         integ_acc = integ_acc + err;
         if (integ_acc > INTEG_MAX)
            integ_acc = INTEG_MAX;
         if (integ_acc < INTEG_MIN)
            integ_acc = INTEG_MIN;
         deriv = err - prev_error;

         acc   = kp_q16 * err + ki_q16 * integ_acc + kd_q16 * deriv;
         drive = acc / (longint'(1) << mpl_pkg::Q_FRAC);

         prev_error = err;
         prev_level = filtered;

         if (drive < -mpl_pkg::DRIVE_LIMIT)
            drive = -mpl_pkg::DRIVE_LIMIT;
         if (drive > mpl_pkg::DRIVE_LIMIT)
            drive = mpl_pkg::DRIVE_LIMIT;
         if (sd == mpl_pkg::SIDE_RIGHT)
            drive = -drive;

         res.drive = mpl_pkg::DRIVE_W'(drive);
         res.speed = mpl_pkg::SPEED_W'(mpl_pkg::BASE_SPEED + drive);
         pending_drive_q.push_back(res);
         level_beats++;
      end
   endtask

   // offer one request beat, sometimes with a random gap in front
   task automatic send_beat(input mpl_pkg::opcode_type op,
                            input logic [mpl_pkg::DIST_W-1:0] distance,
                            input mpl_pkg::side_type sd);
      int gap;
      begin
         gap = 0;
         if (!sender_calm) begin
            if (send_quiet_left > 0)
               send_quiet_left--;
            else if ($urandom_range(0, 1) == 0)
               gap = $urandom_range(1, 12);
            else
               send_quiet_left = $urandom_range(3, 25);
         end
         @(negedge clock);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_bus.valid    <= 1'b1;
         req_bus.opcode   <= op;
         req_bus.distance <= distance;
         req_bus.side     <= sd;
         do
            @(posedge clock);
         while (req_bus.ready !== 1'b1);
         advance_leveler(op, distance, sd);
         beats_sent++;
      end
   endtask

   // drop valid, let every pending response come back, then let the pipe settle
   task automatic wait_for_idle();
      begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         while (pending_drive_q.size() != 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [mpl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mpl_pkg::GAIN_W-1:0] value);
      begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(negedge clock);
         csr_wr_en <= 1'b0;
         case (idx)
            mpl_pkg::CSR_GAIN_P: kp_q16 = longint'(signed'(value));
            mpl_pkg::CSR_GAIN_I: ki_q16 = longint'(signed'(value));
            mpl_pkg::CSR_GAIN_D: kd_q16 = longint'(signed'(value));
            default: ;
         endcase
      end
   endtask

   task automatic write_gain_set(input logic [mpl_pkg::GAIN_W-1:0] kp,
                                 input logic [mpl_pkg::GAIN_W-1:0] ki,
                                 input logic [mpl_pkg::GAIN_W-1:0] kd);
      begin
         write_csr(mpl_pkg::CSR_GAIN_P, kp);
         write_csr(mpl_pkg::CSR_GAIN_I, ki);
         write_csr(mpl_pkg::CSR_GAIN_D, kd);
         gain_settings++;
      end
   endtask

   function automatic logic [mpl_pkg::GAIN_W-1:0] moderate_gain();
      return mpl_pkg::GAIN_W'($urandom_range(0, 1 << 23)) - mpl_pkg::GAIN_W'(1 << 22);
   endfunction

   // response ready: holds, stall bursts and quiet stretches
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (receiver_calm || rsp_quiet_left > 0) begin
         if (rsp_quiet_left > 0)
            rsp_quiet_left--;
         rsp_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
         rsp_stall_left = $urandom_range(1, 12) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_quiet_left = $urandom_range(4, 40);
         rsp_bus.ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_checked++;
         if (pending_drive_q.size() == 0) begin
            report_mismatch("response beat with nothing pending, drive_value", 0,
                            rsp_bus.drive_value);
         end else begin
            want = pending_drive_q.pop_front();
            if (rsp_bus.drive_value !== want.drive)
               report_mismatch("drive_value", want.drive, rsp_bus.drive_value);
            if (rsp_bus.wheel_speed !== want.speed)
               report_mismatch("wheel_speed", want.speed, rsp_bus.wheel_speed);
         end
      end
   end

   // reset gains, big filter steps, prime on the right side
   task automatic test_reset_gains();
      begin
         send_beat(mpl_pkg::OP_PRIME, 16'd0, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_PRIME, 16'hFFFF, mpl_pkg::SIDE_RIGHT);
         send_beat(mpl_pkg::OP_LEVEL, 16'hFFFF, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'd0, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'd0, mpl_pkg::SIDE_RIGHT);
      end
   endtask

   // extreme proportional gains drive the clamp both ways on both sides
   task automatic test_clamp_and_side();
      begin
         wait_for_idle();
         write_gain_set(32'h7FFF_FFFF, 32'h0, 32'h0);
         send_beat(mpl_pkg::OP_PRIME, 16'd0, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'hFFFF, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'hFFFF, mpl_pkg::SIDE_RIGHT);
         send_beat(mpl_pkg::OP_LEVEL, 16'd0, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'hFFFF, mpl_pkg::SIDE_RIGHT);
         wait_for_idle();
         write_csr(mpl_pkg::CSR_GAIN_P, 32'h8000_0000);
         send_beat(mpl_pkg::OP_LEVEL, 16'd0, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'hFFFF, mpl_pkg::SIDE_RIGHT);
      end
   endtask

   // integral and derivative paths, then a write to the spare index
   task automatic test_integral_derivative();
      begin
         wait_for_idle();
         write_gain_set(32'h0, 32'h0001_0000, 32'hFFFF_0000);
         send_beat(mpl_pkg::OP_PRIME, 16'd30000, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'd30700, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'd29000, mpl_pkg::SIDE_RIGHT);
         wait_for_idle();
         write_csr(CSR_SPARE, 32'hFFFF_FFFF);
         send_beat(mpl_pkg::OP_LEVEL, 16'd31000, mpl_pkg::SIDE_LEFT);
         send_beat(mpl_pkg::OP_LEVEL, 16'd100, mpl_pkg::SIDE_RIGHT);
      end
   endtask

   // long response hold while requests keep coming, so the pipe backs up
   task automatic test_backpressure();
      int k;
      begin
         wait_for_idle();
         write_gain_set(32'h0004_0000, 32'h0000_4000, 32'h0002_0000);
         sender_calm = 1;
         rsp_hold_cycles = 80;
         for (k = 0; k < 30; k++)
            send_beat((k < 2) ? mpl_pkg::OP_PRIME : mpl_pkg::OP_LEVEL,
                      16'(20000 + $urandom_range(0, 4000)),
                      mpl_pkg::side_type'($urandom_range(0, 1)));
         sender_calm = 0;
      end
   endtask

   // mostly prime runs followed by level runs on a walking distance, some noise
   task automatic run_leveling_mix(input int n_items);
      int sent, n_prime, n_level, walk, step, k;
      begin
         sent = 0;
         walk = $urandom_range(0, 65535);
         while (sent < n_items) begin
            if ($urandom_range(0, 4) != 0) begin
               n_prime = ($urandom_range(0, 2) != 0)
                         ? mpl_pkg::FILTER_DEPTH
                         : $urandom_range(1, mpl_pkg::FILTER_DEPTH);
               n_level = $urandom_range(3, 30);
               case ($urandom_range(0, 2))
                  0: step = 16;
                  1: step = 600;
                  default: step = 65535;
               endcase
               for (k = 0; k < n_prime + n_level && sent < n_items; k++) begin
                  walk = walk + int'($urandom_range(0, 2 * step)) - step;
                  if (walk < 0)
                     walk = 0;
                  if (walk > 65535)
                     walk = 65535;
                  send_beat((k < n_prime) ? mpl_pkg::OP_PRIME : mpl_pkg::OP_LEVEL,
                            16'(walk), mpl_pkg::side_type'($urandom_range(0, 1)));
                  sent++;
               end
            end else begin
               send_beat(mpl_pkg::opcode_type'($urandom_range(0, 1)), 16'($urandom),
                         mpl_pkg::side_type'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   // random phases under different gain sets; the last one runs without idling
   task automatic test_random_phases();
      int phase;
      begin
         for (phase = 0; phase < 6; phase++) begin
            wait_for_idle();
            case (phase)
               0: write_gain_set(32'd66, 32'h0, 32'h0);
               1: write_gain_set(moderate_gain(), moderate_gain(), moderate_gain());
               2: write_gain_set(32'($urandom), 32'($urandom), 32'($urandom));
               3: write_gain_set(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
               4: write_gain_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
               default: begin
                  write_gain_set(moderate_gain(), moderate_gain(), moderate_gain());
                  sender_calm   = 1;
                  receiver_calm = 1;
               end
            endcase
            run_leveling_mix(95);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = mpl_pkg::OP_PRIME;
      req_bus.distance = '0;
      req_bus.side     = mpl_pkg::SIDE_LEFT;
      rsp_bus.ready    = 1'b0;
      clear_leveler_state();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_gains();
      test_clamp_and_side();
      test_integral_derivative();
      test_backpressure();
      test_random_phases();

      wait_for_idle();
      if (pending_drive_q.size() != 0)
         report_mismatch("responses never returned", 0, pending_drive_q.size());

      $display("covered %0d request beats (%0d level steps) over %0d gain sets",
               beats_sent, level_beats, gain_settings);
      $display("checked %0d response beats, %0d mismatches", results_checked,
               mismatch_count);
      if (mismatch_count == 0)
         $display("moving_average_pid_leveler_top: match");
      else
         $display("moving_average_pid_leveler_top: mismatch");
      $finish;
   end

endmodule
